@@ sv/gha_pkg.sv @@
`default_nettype none

package gha_pkg;

  localparam int FUNC_W   = 2;
  localparam int IDX_IN_W = 8;
  localparam int GEN_IN_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd2;

endpackage

`default_nettype wire

@@ sv/gha_req_if.sv @@
`default_nettype none

interface gha_req_if
  import gha_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [IDX_IN_W-1:0] slot_index;
  logic [GEN_IN_W-1:0] handle_generation;

  modport source (output valid, output func, output slot_index, output handle_generation,
                  input ready);
  modport sink (input valid, input func, input slot_index, input handle_generation,
                output ready);
endinterface

`default_nettype wire

@@ sv/gha_rsp_if.sv @@
`default_nettype none

interface gha_rsp_if
  import gha_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                ok;
  logic [IDX_IN_W-1:0] out_index;
  logic [GEN_IN_W-1:0] out_generation;

  modport source (output valid, output ok, output out_index, output out_generation,
                  input ready);
  modport sink (input valid, input ok, input out_index, input out_generation,
                output ready);
endinterface

`default_nettype wire

@@ sv/generational_handle_allocator_top.sv @@
`default_nettype none

// Generational handle allocator. A request (create, lookup or destroy) is
// taken on req and answered with exactly one transfer on rsp. Handles are an
// index plus a generation; the per-slot generation and the LIFO free list
// live in two single-port-read synchronous memories (SLOTS deep), so each
// request does a read step and then a modify/write-back step, and a create
// that reuses a freed slot adds a second generation-table read fed by the
// free-list read. No clearing pass is needed after reset: the high-water mark
// and free count guard every read. A finished response sits in the output
// register while the next request is already taken.
module generational_handle_allocator_top
  import gha_pkg::*;
#(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  wire        clk,
  input  wire        rst,
  gha_req_if.sink    req,
  gha_rsp_if.source  rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam int GW    = (GEN_BITS > GEN_IN_W) ? GEN_BITS : GEN_IN_W;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_REUSE} state_t;

  state_t              state, state_next;
  logic [FUNC_W-1:0]   func_q;
  logic [CMP_W-1:0]    idx_q;
  logic [GEN_IN_W-1:0] gen_q;
  logic [CNT_W-1:0]    high_water, high_water_next;
  logic [CNT_W-1:0]    free_count, free_count_next;

  logic [GEN_BITS-1:0] gt_mem [SLOTS];
  logic [IDX_W-1:0]    fs_mem [SLOTS];
  logic [GEN_BITS-1:0] gt_rdata;
  logic [IDX_W-1:0]    fs_rdata;

  logic                gt_re, gt_we, fs_re, fs_we;
  logic [IDX_W-1:0]    gt_raddr, gt_waddr, fs_raddr, fs_waddr, fs_wdata;
  logic [GEN_BITS-1:0] gt_wdata;

  logic                res_load, res_ok;
  logic [IDX_IN_W-1:0] res_idx;
  logic [GEN_IN_W-1:0] res_gen;

  logic                rsp_valid, rsp_ok;
  logic [IDX_IN_W-1:0] rsp_idx;
  logic [GEN_IN_W-1:0] rsp_gen;

  logic out_free, accept, handle_ok;

  assign req.ready          = (state == S_IDLE) && !rst;
  assign accept             = req.valid && req.ready;
  assign out_free           = !rsp_valid || rsp.ready;
  assign rsp.valid          = rsp_valid;
  assign rsp.ok             = rsp_ok;
  assign rsp.out_index      = rsp_idx;
  assign rsp.out_generation = rsp_gen;

  assign handle_ok = (idx_q < CMP_W'(high_water)) && (GW'(gt_rdata) == GW'(gen_q));

  always_comb begin
    state_next      = state;
    high_water_next = high_water;
    free_count_next = free_count;
    gt_re    = 1'b0;
    gt_raddr = IDX_W'(req.slot_index);
    fs_re    = 1'b0;
    fs_raddr = IDX_W'(free_count - 1'b1);
    gt_we    = 1'b0;
    gt_waddr = IDX_W'(idx_q);
    gt_wdata = gt_rdata + 1'b1;
    fs_we    = 1'b0;
    fs_waddr = IDX_W'(free_count);
    fs_wdata = IDX_W'(idx_q);
    res_load = 1'b0;
    res_ok   = 1'b0;
    res_idx  = '0;
    res_gen  = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          gt_re      = 1'b1;
          fs_re      = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (func_q == FUNC_CREATE && free_count != '0) begin
          gt_re           = 1'b1;
          gt_raddr        = fs_rdata;
          free_count_next = free_count - 1'b1;
          state_next      = S_REUSE;
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          case (func_q)
            FUNC_CREATE: begin
              if (high_water < CNT_W'(SLOTS)) begin
                gt_we           = 1'b1;
                gt_waddr        = IDX_W'(high_water);
                gt_wdata        = '0;
                high_water_next = high_water + 1'b1;
                res_ok          = 1'b1;
                res_idx         = IDX_IN_W'(high_water);
              end
            end
            FUNC_LOOKUP: begin
              if (handle_ok) begin
                res_ok  = 1'b1;
                res_idx = IDX_IN_W'(idx_q);
                res_gen = gen_q;
              end
            end
            FUNC_DESTROY: begin
              if (handle_ok && free_count < CNT_W'(SLOTS)) begin
                gt_we           = 1'b1;
                fs_we           = 1'b1;
                free_count_next = free_count + 1'b1;
                res_ok          = 1'b1;
                res_idx         = IDX_IN_W'(idx_q);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REUSE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_ok     = 1'b1;
          res_idx    = IDX_IN_W'(idx_q);
          res_gen    = GEN_IN_W'(gt_rdata);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (gt_we) gt_mem[gt_waddr] <= gt_wdata;
    if (gt_re) gt_rdata <= gt_mem[gt_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    if (fs_re) fs_rdata <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      high_water <= '0;
      free_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      high_water <= high_water_next;
      free_count <= free_count_next;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      func_q <= req.func;
      idx_q  <= CMP_W'(req.slot_index);
      gen_q  <= req.handle_generation;
    end else if (state == S_FETCH && state_next == S_REUSE) begin
      idx_q <= CMP_W'(fs_rdata);
    end
    if (res_load) begin
      rsp_ok  <= res_ok;
      rsp_idx <= res_idx;
      rsp_gen <= res_gen;
    end
  end

endmodule

`default_nettype wire

@@ dv/gha_tb_pkg.sv @@
`timescale 1ns / 100ps

package gha_tb_pkg;
  import gha_pkg::*;

  localparam int SLOT_COUNT = 256;
  localparam int REPORT_CAP = 40;

  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

  typedef struct {
    int unsigned         seq;
    logic [FUNC_W-1:0]   func;
    logic                ok;
    logic [IDX_IN_W-1:0] out_index;
    logic [GEN_IN_W-1:0] out_generation;
  } handle_answer_t;

  class handle_scoreboard;
    int unsigned         high_water;
    int unsigned         free_count;
    logic [GEN_IN_W-1:0] gen_table [SLOT_COUNT];
    logic [IDX_IN_W-1:0] free_list [SLOT_COUNT];
    handle_answer_t      answers [$];

    int unsigned n_requests;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_create_full;
    int unsigned n_stack_full;
    int unsigned n_wraps;

    function new();
      high_water    = 0;
      free_count    = 0;
      n_requests    = 0;
      n_checked     = 0;
      n_errors      = 0;
      n_create_full = 0;
      n_stack_full  = 0;
      n_wraps       = 0;
      foreach (gen_table[i]) gen_table[i] = '0;
      foreach (free_list[i]) free_list[i] = '0;
    endfunction

    function bit handle_live(logic [IDX_IN_W-1:0] idx, logic [GEN_IN_W-1:0] gen);
      return (idx < high_water) && (gen_table[idx] == gen);
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [IDX_IN_W-1:0] idx,
                               logic [GEN_IN_W-1:0] gen);
      handle_answer_t      a;
      logic [IDX_IN_W-1:0] slot;
      a.seq            = n_requests;
      a.func           = func;
      a.ok             = 1'b0;
      a.out_index      = '0;
      a.out_generation = '0;
      n_requests++;
      case (func)
        FUNC_CREATE: begin
          if (free_count > 0) begin
            free_count--;
            slot             = free_list[free_count];
            a.ok             = 1'b1;
            a.out_index      = slot;
            a.out_generation = gen_table[slot];
          end else if (high_water < SLOT_COUNT) begin
            slot            = IDX_IN_W'(high_water);
            gen_table[slot] = '0;
            high_water++;
            a.ok        = 1'b1;
            a.out_index = slot;
          end else begin
            n_create_full++;
          end
        end
        FUNC_LOOKUP: begin
          if (handle_live(idx, gen)) begin
            a.ok             = 1'b1;
            a.out_index      = idx;
            a.out_generation = gen;
          end
        end
        FUNC_DESTROY: begin
          if (handle_live(idx, gen) && free_count < SLOT_COUNT) begin
            if (gen_table[idx] == '1) n_wraps++;
            gen_table[idx]        = gen_table[idx] + 1'b1;
            free_list[free_count] = idx;
            free_count++;
            a.ok        = 1'b1;
            a.out_index = idx;
          end else if (handle_live(idx, gen)) begin
            n_stack_full++;
          end
        end
        default: ;
      endcase
      answers.insert(answers.size(), a);
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      if (n_errors <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_response(logic ok, logic [IDX_IN_W-1:0] idx, logic [GEN_IN_W-1:0] gen);
      handle_answer_t want;
      if (answers.size() == 0) begin
        report_mismatch($sformatf("response with nothing outstanding: ok=%0b index=%0d gen=%0d",
                                  ok, idx, gen));
        return;
      end
      want = answers.pop_front();
      n_checked++;
      if (ok !== want.ok)
        report_mismatch($sformatf("request %0d func %0d: ok %0b, want %0b",
                                  want.seq, want.func, ok, want.ok));
      if (idx !== want.out_index)
        report_mismatch($sformatf("request %0d func %0d: out_index %0d, want %0d",
                                  want.seq, want.func, idx, want.out_index));
      if (gen !== want.out_generation)
        report_mismatch($sformatf("request %0d func %0d: out_generation %0d, want %0d",
                                  want.seq, want.func, gen, want.out_generation));
    endtask
  endclass

endpackage

@@ dv/tb_generational_handle_allocator_top.sv @@
`timescale 1ns / 100ps

module tb_generational_handle_allocator_top;
  import gha_pkg::*;
  import gha_tb_pkg::*;

  localparam int QUIET_LIMIT      = 2000;
  localparam int RANDOM_PER_PHASE = 175;
  localparam int RECYCLE_ROUNDS   = 32;

  logic        clk;
  logic        rst;
  int unsigned gap_pct;
  int unsigned stall_pct;

  handle_scoreboard sb = new();

  gha_req_if req_ch ();
  gha_rsp_if rsp_ch ();

  generational_handle_allocator_top #(
    .SLOTS    (SLOT_COUNT),
    .GEN_BITS (GEN_IN_W)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_response(rsp_ch.ok, rsp_ch.out_index, rsp_ch.out_generation);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_req(input logic [FUNC_W-1:0] func, input logic [IDX_IN_W-1:0] idx,
                          input logic [GEN_IN_W-1:0] gen);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.func              <= func;
    req_ch.slot_index        <= idx;
    req_ch.handle_generation <= gen;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(func, idx, gen);
  endtask

  // create ignores its handle fields; fill them with noise
  task automatic send_create();
    send_req(FUNC_CREATE, IDX_IN_W'($urandom), GEN_IN_W'($urandom));
  endtask

  task automatic run_directed();
    send_req(FUNC_LOOKUP, '0, '0);
    send_req(FUNC_DESTROY, '0, '0);
    send_create();
    send_create();
    send_req(FUNC_LOOKUP, 8'd1, 16'd0);
    send_req(FUNC_LOOKUP, 8'd1, 16'd1);
    send_req(FUNC_LOOKUP, '1, '1);
    send_req(FUNC_DESTROY, 8'd1, 16'd0);
    send_req(FUNC_LOOKUP, 8'd1, 16'd1);
    send_req(FUNC_LOOKUP, 8'd1, 16'd0);
    send_req(FUNC_DESTROY, 8'd1, 16'd1);
    send_req(FUNC_DESTROY, 8'd0, '1);
    send_req(FUNC_UNKNOWN, '1, '1);
    send_req(FUNC_UNKNOWN, '0, '0);
    send_create();
    send_create();
    send_create();
    send_req(FUNC_DESTROY, 8'd0, 16'd0);
    send_create();
    send_req(FUNC_LOOKUP, 8'd0, 16'd1);
    send_req(FUNC_LOOKUP, 8'd2, 16'h8000);
  endtask

  // fill every slot, overflow the pool, then free all and overflow the free list
  task automatic run_exhaustion();
    logic [IDX_IN_W-1:0] slot;
    while (sb.free_count != 0 || sb.high_water < SLOT_COUNT) send_create();
    send_create();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot = IDX_IN_W'(i);
      send_req(FUNC_DESTROY, slot, sb.gen_table[slot]);
    end
    slot = IDX_IN_W'($urandom_range(SLOT_COUNT - 1));
    send_req(FUNC_DESTROY, slot, sb.gen_table[slot]);
    send_req(FUNC_LOOKUP, slot, sb.gen_table[slot]);
  endtask

  task automatic send_random_item();
    int unsigned         roll;
    int unsigned         pick;
    logic [FUNC_W-1:0]   func;
    logic [IDX_IN_W-1:0] idx;
    logic [GEN_IN_W-1:0] gen;
    roll = $urandom_range(99);
    idx  = IDX_IN_W'($urandom);
    gen  = GEN_IN_W'($urandom);
    if (roll < 36) func = FUNC_CREATE;
    else if (roll < 66) func = FUNC_LOOKUP;
    else if (roll < 95) func = FUNC_DESTROY;
    else func = FUNC_UNKNOWN;
    if ((func == FUNC_LOOKUP || func == FUNC_DESTROY) && sb.high_water > 0) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        idx = IDX_IN_W'($urandom_range(sb.high_water - 1));
        gen = sb.gen_table[idx];
      end else if (pick < 85) begin
        idx = IDX_IN_W'($urandom_range(sb.high_water - 1));
        gen = sb.gen_table[idx] ^ (GEN_IN_W'(1) << $urandom_range(GEN_IN_W - 1));
      end
    end
    send_req(func, idx, gen);
  endtask

  task automatic run_random(input int unsigned gap, input int unsigned stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (RANDOM_PER_PHASE) send_random_item();
  endtask

  // recycle one slot back to back a number of times
  task automatic run_generation_wrap();
    logic [IDX_IN_W-1:0] slot;
    slot = IDX_IN_W'($urandom_range(sb.high_water - 1));
    if (sb.gen_table[slot] == '0 && sb.free_count == 0) send_create();
    for (int k = 0; k < RECYCLE_ROUNDS; k++) begin
      if (sb.free_count >= SLOT_COUNT) send_create();
      send_req(FUNC_DESTROY, slot, sb.gen_table[slot]);
      send_create();
    end
    send_req(FUNC_LOOKUP, slot, sb.gen_table[slot]);
  endtask

  initial begin
    rst                      = 1'b1;
    req_ch.valid             = 1'b0;
    req_ch.func              = FUNC_CREATE;
    req_ch.slot_index        = '0;
    req_ch.handle_generation = '0;
    gap_pct                  = 0;
    stall_pct                = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    gap_pct   = 17;
    stall_pct = 17;
    run_exhaustion();
    run_random(0, 0);
    run_random(79, 0);
    run_random(0, 79);
    run_random(17, 17);
    gap_pct   = 0;
    stall_pct = 0;
    run_generation_wrap();
    req_ch.valid <= 1'b0;

    while (sb.answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests, %0d responses checked, %0d mismatches", sb.n_requests,
             sb.n_checked, sb.n_errors);
    $display("pool exhausted %0d times, free list full %0d times, %0d generation wraps",
             sb.n_create_full, sb.n_stack_full, sb.n_wraps);
    if (sb.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ generational_handle_allocator_top.f @@
sv/gha_pkg.sv
sv/gha_req_if.sv
sv/gha_rsp_if.sv
sv/generational_handle_allocator_top.sv
dv/gha_tb_pkg.sv
dv/tb_generational_handle_allocator_top.sv
